FILE: hdl/ctb_pkg.sv
// Package for the countdown timer bank: request codes, beat layout,
// controller state type and the command/status structs.
// No dependencies.
`default_nettype none

package ctb_pkg;

    // Default number of timers in the bank
    localparam int TIMER_COUNT_DEF = 8;

    // Request codes carried in req_type
    localparam logic [2:0] REQ_TICK       = 3'd0;
    localparam logic [2:0] REQ_START_ONCE = 3'd1;
    localparam logic [2:0] REQ_START_AUTO = 3'd2;
    localparam logic [2:0] REQ_STOP       = 3'd3;
    localparam logic [2:0] REQ_CHECK      = 3'd4;
    localparam logic [2:0] REQ_DELAY      = 3'd5;

    // Prescaler terminal counts (10-tick and 1000-tick events)
    localparam logic [3:0] FAST_LAST = 4'd9;
    localparam logic [9:0] SLOW_LAST = 10'd999;

    // Run-time counter wraps to zero after this value
    localparam logic [31:0] RUN_TIME_MAX = 32'hFFFF_FFFE;

    // Beat widths
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 40;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK,
        ST_POST
    } ctb_state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // latch the input beat
        logic exec;      // carry out the request / global tick updates
        logic walk;      // one timer entry per cycle
        logic load_out;  // move the result into the output register
    } ctb_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_tick;   // latched request is a tick
        logic walk_last; // entry in hand is the last timer
        logic out_free;  // output register can take a result
    } ctb_stat_t;

endpackage

`default_nettype wire

FILE: hdl/ctb_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ctb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  wire logic                                    aclk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hdl/ctb_datapath.sv
// Datapath of the countdown timer bank: timer RAM, per-timer flags, delay,
// run-time and prescaler counters, and the result register.
// Depends on ctb_pkg and ctb_ram.
`default_nettype none

module ctb_datapath #(
    parameter int TIMER_COUNT = ctb_pkg::TIMER_COUNT_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [ctb_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire ctb_pkg::ctb_cmd_t             cmd,
    output ctb_pkg::ctb_stat_t                 stat,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [ctb_pkg::M_TDATA_W-1:0] m_tdata
);

    import ctb_pkg::*;

    localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam logic [8:0]       COUNT_9  = 9'(TIMER_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_COUNT - 1);

    // latched request
    logic [2:0]  req_reg;
    logic [7:0]  id_reg;
    logic [31:0] period_reg;

    // per-timer state kept in flops
    logic valid_reg   [TIMER_COUNT];
    logic expired_reg [TIMER_COUNT];
    logic auto_reg    [TIMER_COUNT];

    logic [IDX_W-1:0] idx_reg;
    logic [31:0]      delay_left_reg;
    logic             delay_flag_reg;
    logic [31:0]      tick_total_reg;
    logic [3:0]       fast_reg;
    logic [9:0]       slow_reg;
    logic             expired_res_reg;
    logic             scan_res_reg;
    logic             second_res_reg;
    logic             m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic             id_ok;
    logic [IDX_W-1:0] req_idx;
    logic             is_tick;
    logic             is_start;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [63:0]      ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [63:0]      ram_rdata;

    logic [31:0] cur_rem;
    logic [31:0] cur_reload;
    logic        cur_live;
    logic        hit_zero;
    logic [31:0] wb_rem;

    // request decode
    assign id_ok    = {1'b0, id_reg} < COUNT_9;
    assign req_idx  = id_reg[IDX_W-1:0];
    assign is_tick  = (req_reg == REQ_TICK);
    assign is_start = (req_reg == REQ_START_ONCE) || (req_reg == REQ_START_AUTO);

    assign stat.is_tick   = is_tick;
    assign stat.walk_last = (idx_reg == LAST_IDX);
    assign stat.out_free  = !m_tvalid_reg || m_tready;

    // capture the input beat
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg    <= s_tdata[2:0];
            id_reg     <= s_tdata[10:3];
            period_reg <= s_tdata[42:11];
        end
    end

    // entry under the walk; an entry never written reads as zero
    assign cur_rem    = valid_reg[idx_reg] ? ram_rdata[31:0]  : '0;
    assign cur_reload = valid_reg[idx_reg] ? ram_rdata[63:32] : '0;
    assign cur_live   = (cur_rem != '0);
    assign hit_zero   = (cur_rem == 32'd1);
    assign wb_rem     = (hit_zero && auto_reg[idx_reg]) ? cur_reload : cur_rem - 32'd1;

    // RAM port control: walk writes back, start writes {reload, remaining}
    always_comb begin
        ram_re    = (cmd.exec && is_tick) || (cmd.walk && !stat.walk_last);
        ram_raddr = cmd.walk ? idx_reg + 1'b1 : '0;
        if (cmd.walk) begin
            ram_we    = cur_live;
            ram_waddr = idx_reg;
            ram_wdata = {cur_reload, wb_rem};
        end else begin
            ram_we    = cmd.exec && is_start && id_ok;
            ram_waddr = req_idx;
            ram_wdata = {period_reg, period_reg};
        end
    end

    ctb_ram #(
        .WIDTH (64),
        .DEPTH (TIMER_COUNT)
    ) u_timer_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // walk index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (cmd.exec) begin
            idx_reg <= '0;
        end else if (cmd.walk) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    // per-timer flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TIMER_COUNT; i++) begin
                valid_reg[i]   <= 1'b0;
                expired_reg[i] <= 1'b0;
                auto_reg[i]    <= 1'b0;
            end
        end else if (cmd.exec && id_ok) begin
            if (is_start) begin
                valid_reg[req_idx]   <= 1'b1;
                expired_reg[req_idx] <= 1'b0;
                auto_reg[req_idx]    <= (req_reg == REQ_START_AUTO);
            end else if (req_reg == REQ_STOP) begin
                valid_reg[req_idx]   <= 1'b0;
                expired_reg[req_idx] <= 1'b0;
                auto_reg[req_idx]    <= 1'b0;
            end else if (req_reg == REQ_CHECK) begin
                expired_reg[req_idx] <= 1'b0;
            end
        end else if (cmd.walk && hit_zero) begin
            expired_reg[idx_reg] <= 1'b1;
        end
    end

    // global counters and per-request result bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_left_reg  <= '0;
            delay_flag_reg  <= 1'b0;
            tick_total_reg  <= '0;
            fast_reg        <= '0;
            slow_reg        <= '0;
            expired_res_reg <= 1'b0;
            scan_res_reg    <= 1'b0;
            second_res_reg  <= 1'b0;
        end else if (cmd.exec) begin
            expired_res_reg <= (req_reg == REQ_CHECK) && id_ok && expired_reg[req_idx];
            scan_res_reg    <= is_tick && (fast_reg == FAST_LAST);
            second_res_reg  <= is_tick && (slow_reg == SLOW_LAST);
            if (is_tick) begin
                if (delay_left_reg != '0) begin
                    delay_left_reg <= delay_left_reg - 32'd1;
                    if (delay_left_reg == 32'd1) begin
                        delay_flag_reg <= 1'b1;
                    end
                end
                tick_total_reg <= (tick_total_reg == RUN_TIME_MAX) ? '0
                                                                   : tick_total_reg + 32'd1;
                fast_reg <= (fast_reg == FAST_LAST) ? '0 : fast_reg + 4'd1;
                slow_reg <= (slow_reg == SLOW_LAST) ? '0 : slow_reg + 10'd1;
            end else if (req_reg == REQ_DELAY && period_reg != '0) begin
                // a length of one is stretched to two
                delay_left_reg <= (period_reg == 32'd1) ? 32'd2 : period_reg;
                delay_flag_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_tdata_reg <= {4'b0, second_res_reg, scan_res_reg, tick_total_reg,
                            delay_flag_reg, expired_res_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // the run-time count never shows the all-ones value
    a_run_time_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        tick_total_reg != '1)
        else $error("run-time counter reached all ones");

    // prescalers stay within their periods
    a_prescale_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (fast_reg <= FAST_LAST) && (slow_reg <= SLOW_LAST))
        else $error("prescaler out of range");

    // the delay flag rises only as a tick is carried out
    a_delay_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(delay_flag_reg) |-> $past(cmd.exec && is_tick))
        else $error("delay flag set outside a tick");

    // a new result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten");

endmodule

`default_nettype wire

FILE: hdl/ctb_ctrl.sv
// Controller of the countdown timer bank: sequences capture, execution,
// the walk over the timer entries and the hand-off to the result register.
// Depends on ctb_pkg.
`default_nettype none

module ctb_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire ctb_pkg::ctb_stat_t stat,
    output ctb_pkg::ctb_cmd_t       cmd
);

    import ctb_pkg::*;

    ctb_state_t state_reg;
    ctb_state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = stat.is_tick ? ST_WALK : ST_POST;
            end
            ST_WALK: begin
                cmd.walk = 1'b1;
                if (stat.walk_last) begin
                    state_next = ST_POST;
                end
            end
            ST_POST: begin
                cmd.load_out = stat.out_free;
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/countdown_timer_bank.sv
// Countdown timer bank, a 1 ms tick request walks TIMER_COUNT timers. Each
// input beat is one request and gives exactly one result beat. A request
// other than a tick passes through capture, execute and the load of the
// result register; a tick also walks the timer RAM between execute and
// load, one entry read, decremented and written back per cycle. The load
// waits while an earlier result is still held and not taken. A new request
// is accepted as soon as the previous one has been placed in the result
// register, even while that result still waits for m_tready. Timer entries
// need no clearing pass after reset.
// Depends on ctb_pkg, ctb_ctrl, ctb_datapath and ctb_ram.
`default_nettype none

module countdown_timer_bank #(
    parameter int TIMER_COUNT = ctb_pkg::TIMER_COUNT_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // req_type[2:0], timer_id[10:3], period[42:11], zero fill to 48 bits
    input  wire logic [ctb_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // expired[0], delay_done[1], run_time[33:2], scan_event[34],
    // second_event[35], zero fill to 40 bits
    output logic      [ctb_pkg::M_TDATA_W-1:0] m_tdata
);

    import ctb_pkg::*;

    ctb_cmd_t  cmd;
    ctb_stat_t stat;

    ctb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ctb_datapath #(
        .TIMER_COUNT (TIMER_COUNT)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

FILE: tb/sv/countdown_timer_bank_checker.sv
// Checker for the countdown timer bank: watches both stream channels, keeps
// its own copy of the timer state and compares every result beat in order.
// Depends on ctb_pkg for request codes, prescaler limits and beat widths.
`timescale 1ns / 1ps

module countdown_timer_bank_checker #(
    parameter int TIMER_COUNT = ctb_pkg::TIMER_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [ctb_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [ctb_pkg::M_TDATA_W-1:0] m_tdata,
    output int                            fail_count,
    output int                            pending,
    output int                            checked,
    output int                            expired_hits,
    output int                            second_hits
);
    import ctb_pkg::*;

    // Result beat layout, expired in bit 0
    typedef struct packed {
        logic        second_event;
        logic        scan_event;
        logic [31:0] run_time;
        logic        delay_done;
        logic        expired;
    } status_beat_t;

    // Shadow copy of the bank
    logic [31:0] remaining [TIMER_COUNT];
    logic [31:0] reload    [TIMER_COUNT];
    logic        exp_flag  [TIMER_COUNT];
    logic        auto_mode [TIMER_COUNT];
    logic [31:0] delay_left;
    logic        delay_flag;
    logic [31:0] tick_total;
    logic [3:0]  fast_cnt;
    logic [9:0]  slow_cnt;

    status_beat_t status_q[$];

    // Apply one request to the shadow state, return the status it reports
    function automatic status_beat_t apply_request(logic [2:0] req, logic [7:0] id,
                                                   logic [31:0] period);
        status_beat_t r;
        logic         in_range;
        int           n;
        r        = '0;
        in_range = (id < TIMER_COUNT);
        case (req)
            REQ_TICK: begin
                if (delay_left != 32'd0) begin
                    delay_left = delay_left - 32'd1;
                    if (delay_left == 32'd0) delay_flag = 1'b1;
                end
                for (n = 0; n < TIMER_COUNT; n++) begin
                    if (remaining[n] != 32'd0) begin
                        remaining[n] = remaining[n] - 32'd1;
                        if (remaining[n] == 32'd0) begin
                            exp_flag[n] = 1'b1;
                            if (auto_mode[n]) remaining[n] = reload[n];
                        end
                    end
                end
                tick_total = (tick_total == RUN_TIME_MAX) ? 32'd0 : tick_total + 32'd1;
                if (fast_cnt == FAST_LAST) begin
                    fast_cnt     = '0;
                    r.scan_event = 1'b1;
                end else begin
                    fast_cnt = fast_cnt + 4'd1;
                end
                if (slow_cnt == SLOW_LAST) begin
                    slow_cnt       = '0;
                    r.second_event = 1'b1;
                end else begin
                    slow_cnt = slow_cnt + 10'd1;
                end
            end
            REQ_START_ONCE, REQ_START_AUTO: begin
                if (in_range) begin
                    remaining[id] = period;
                    reload[id]    = period;
                    exp_flag[id]  = 1'b0;
                    auto_mode[id] = (req == REQ_START_AUTO);
                end
            end
            REQ_STOP: begin
                // reload value survives a stop
                if (in_range) begin
                    remaining[id] = '0;
                    exp_flag[id]  = 1'b0;
                    auto_mode[id] = 1'b0;
                end
            end
            REQ_CHECK: begin
                if (in_range && exp_flag[id]) begin
                    exp_flag[id] = 1'b0;
                    r.expired    = 1'b1;
                end
            end
            REQ_DELAY: begin
                // zero is ignored, one is stretched to two
                if (period != 32'd0) begin
                    delay_left = (period == 32'd1) ? 32'd2 : period;
                    delay_flag = 1'b0;
                end
            end
            default: ;
        endcase
        r.delay_done = delay_flag;
        r.run_time   = tick_total;
        return r;
    endfunction

    // Sample both channels at the rising edge
    always @(posedge aclk) begin
        status_beat_t want;
        status_beat_t got;
        if (!aresetn) begin
            for (int n = 0; n < TIMER_COUNT; n++) begin
                remaining[n] = '0;
                reload[n]    = '0;
                exp_flag[n]  = 1'b0;
                auto_mode[n] = 1'b0;
            end
            delay_left   = '0;
            delay_flag   = 1'b0;
            tick_total   = '0;
            fast_cnt     = '0;
            slow_cnt     = '0;
            status_q.delete();
            fail_count   = 0;
            checked      = 0;
            expired_hits = 0;
            second_hits  = 0;
        end else begin
            // request beat: predict its status
            if (s_tvalid && s_tready)
                status_q.push_back(apply_request(s_tdata[2:0], s_tdata[10:3], s_tdata[42:11]));

            // result beat: compare against the oldest prediction
            if (m_tvalid && m_tready) begin
                if (status_q.size() == 0) begin
                    $error("result beat with no request outstanding: %h", m_tdata);
                    fail_count++;
                end else begin
                    want = status_q.pop_front();
                    got  = status_beat_t'(m_tdata[$bits(status_beat_t)-1:0]);
                    checked++;
                    if (got.expired !== want.expired) begin
                        $error("expired: expected %0b, got %0b", want.expired, got.expired);
                        fail_count++;
                    end
                    if (got.delay_done !== want.delay_done) begin
                        $error("delay_done: expected %0b, got %0b",
                               want.delay_done, got.delay_done);
                        fail_count++;
                    end
                    if (got.run_time !== want.run_time) begin
                        $error("run_time: expected %0d, got %0d", want.run_time, got.run_time);
                        fail_count++;
                    end
                    if (got.scan_event !== want.scan_event) begin
                        $error("scan_event: expected %0b, got %0b",
                               want.scan_event, got.scan_event);
                        fail_count++;
                    end
                    if (got.second_event !== want.second_event) begin
                        $error("second_event: expected %0b, got %0b",
                               want.second_event, got.second_event);
                        fail_count++;
                    end
                    if (want.expired) expired_hits++;
                    if (want.second_event) second_hits++;
                end
            end
        end
        pending = status_q.size();
    end

endmodule

FILE: tb/sv/countdown_timer_bank_test.sv
// Top of the countdown timer bank testbench: clock, reset, request stimulus,
// result back-pressure and the final verdict.
// Depends on ctb_pkg, countdown_timer_bank and countdown_timer_bank_checker.
`timescale 1ns / 1ps

module countdown_timer_bank_test;
    import ctb_pkg::*;

    localparam int N_TIMERS = TIMER_COUNT_DEF;

    // Request codes the block does not use
    localparam logic [2:0] REQ_SPARE_LO = 3'd6;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;

    localparam int     RANDOM_BEATS = 1800;
    localparam int     MIN_TICKS    = 1010;   // enough for one thousand-tick event
    localparam int     PHASE_BEATS  = 250;
    localparam int     HOLD_CYCLES  = 150;
    localparam int     DRAIN_CYCLES = 40;
    localparam longint CYCLE_LIMIT  = 1_000_000;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int     fail_count, pending, checked, expired_hits, second_hits;
    int     beats_sent = 0;
    int     ticks_sent = 0;
    longint cycles     = 0;
    bit     steady     = 1'b0;   // no idling on either side
    bit     hold_off   = 1'b0;   // ask the receiver for one long stall

    countdown_timer_bank #(.TIMER_COUNT(N_TIMERS)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    countdown_timer_bank_checker #(.TIMER_COUNT(N_TIMERS)) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .checked      (checked),
        .expired_hits (expired_hits),
        .second_hits  (second_hits)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("countdown_timer_bank_test: done, errors");
            $finish;
        end
    end

    // Idle length: mostly short, now and then long
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one request beat, return at the falling edge after acceptance
    task automatic send_request(input logic [2:0] req, input logic [7:0] id,
                                input logic [31:0] period);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(0, 99) < 35) gap = idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - 43){1'b0}}, period, id, req};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        beats_sent++;
        if (req == REQ_TICK) ticks_sent++;
    endtask

    // Random request, weighted toward ticks and in-range timers
    task automatic send_random_request();
        logic [2:0]  req;
        logic [7:0]  id;
        logic [31:0] period;
        int          pick;
        int          sel;
        pick = $urandom_range(0, 99);
        if (pick < 62)      req = REQ_TICK;
        else if (pick < 71) req = REQ_START_ONCE;
        else if (pick < 80) req = REQ_START_AUTO;
        else if (pick < 85) req = REQ_STOP;
        else if (pick < 94) req = REQ_CHECK;
        else if (pick < 98) req = REQ_DELAY;
        else                req = ($urandom_range(0, 1) != 0) ? REQ_SPARE_HI : REQ_SPARE_LO;

        id = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, N_TIMERS - 1))
                                          : 8'($urandom_range(0, 255));

        sel = $urandom_range(0, 99);
        if (req == REQ_START_ONCE || req == REQ_START_AUTO) begin
            if (sel < 8)       period = 32'd0;
            else if (sel < 88) period = $urandom_range(1, 24);
            else               period = $urandom();
        end else if (req == REQ_DELAY) begin
            if (sel < 10)      period = 32'd0;
            else if (sel < 20) period = 32'd1;
            else if (sel < 85) period = $urandom_range(2, 40);
            else               period = $urandom();
        end else begin
            period = $urandom();
        end
        send_request(req, id, period);
    endtask

    // Result side back-pressure
    initial begin
        int   len;
        logic lvl;
        @(negedge aclk);
        forever begin
            if (hold_off) begin
                lvl      = 1'b0;
                len      = HOLD_CYCLES;
                hold_off = 1'b0;
            end else if (steady) begin
                lvl = 1'b1;
                len = 1;
            end else begin
                lvl = ($urandom_range(0, 99) < 70);
                len = lvl ? $urandom_range(1, 6) : idle_len();
            end
            m_tready <= lvl;
            repeat (len) @(negedge aclk);
        end
    end

    // Stimulus and verdict
    initial begin
        int n;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // fresh bank reads clear
        send_request(REQ_CHECK, 8'd0, 32'd0);
        // one-shot of one tick, flag is sticky until read once
        send_request(REQ_START_ONCE, 8'd0, 32'd1);
        send_request(REQ_TICK, 8'd0, 32'd0);
        send_request(REQ_CHECK, 8'd0, 32'd0);
        send_request(REQ_CHECK, 8'd0, 32'd0);
        // auto timer on the last slot reloads
        send_request(REQ_START_AUTO, 8'(N_TIMERS - 1), 32'd2);
        send_request(REQ_TICK, 8'd0, 32'd0);
        send_request(REQ_TICK, 8'd0, 32'd0);
        send_request(REQ_CHECK, 8'(N_TIMERS - 1), 32'd0);
        // zero period leaves the timer idle
        send_request(REQ_START_ONCE, 8'd1, 32'd0);
        send_request(REQ_TICK, 8'd0, 32'd0);
        send_request(REQ_CHECK, 8'd1, 32'd0);
        // out-of-range ids
        send_request(REQ_START_ONCE, 8'(N_TIMERS), 32'd1);
        send_request(REQ_CHECK, 8'hFF, 32'd0);
        send_request(REQ_STOP, 8'd200, 32'hFFFF_FFFF);
        // stop kills the auto timer
        send_request(REQ_STOP, 8'(N_TIMERS - 1), 32'd0);
        send_request(REQ_TICK, 8'd0, 32'd0);
        send_request(REQ_CHECK, 8'(N_TIMERS - 1), 32'd0);
        // delay: zero ignored, one stretched to two, new start clears done
        send_request(REQ_DELAY, 8'd0, 32'd0);
        send_request(REQ_DELAY, 8'd0, 32'd1);
        send_request(REQ_TICK, 8'd0, 32'd0);
        send_request(REQ_TICK, 8'd0, 32'd0);
        send_request(REQ_DELAY, 8'd0, 32'd3);
        // unused codes, alternating field bits
        send_request(REQ_SPARE_LO, 8'hAA, 32'h5555_5555);
        send_request(REQ_SPARE_HI, 8'h55, 32'hAAAA_AAAA);
        // full-scale periods
        send_request(REQ_START_AUTO, 8'd6, 32'hFFFF_FFFF);
        send_request(REQ_START_ONCE, 8'd5, 32'hFFFF_FFFF);

        // long receiver stall while requests keep coming
        hold_off = 1'b1;
        steady   = 1'b1;
        for (n = 0; n < 40; n++) send_random_request();
        steady = 1'b0;

        // random phases, some without any idling
        n = 0;
        while (n < RANDOM_BEATS || ticks_sent < MIN_TICKS) begin
            if (n % PHASE_BEATS == 0) steady = ($urandom_range(0, 3) == 0);
            send_random_request();
            n++;
        end
        steady   = 1'b0;
        s_tvalid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d requests (%0d ticks), checked %0d result beats",
                 beats_sent, ticks_sent, checked);
        $display("read back %0d expired timers, saw %0d thousand-tick events",
                 expired_hits, second_hits);
        if (fail_count == 0 && pending == 0) begin
            $display("countdown_timer_bank_test: done, clean");
        end else begin
            $display("countdown_timer_bank_test: done, errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/ctb_pkg.sv
hdl/ctb_ram.sv
hdl/ctb_datapath.sv
hdl/ctb_ctrl.sv
hdl/countdown_timer_bank.sv
tb/sv/countdown_timer_bank_checker.sv
tb/sv/countdown_timer_bank_test.sv
